// ===== rtl/gyro_temperature_offset_compensator_top_defines.svh =====
// Assertion macros for the gyro temperature offset compensator checker.
// Used by gtoc_checker only; no other dependencies.
`ifndef GYRO_TEMPERATURE_OFFSET_COMPENSATOR_TOP_DEFINES_SVH
`define GYRO_TEMPERATURE_OFFSET_COMPENSATOR_TOP_DEFINES_SVH
// assert that a condition implies a consequence on the same edge
`define GTOC_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("gtoc check failed");
// assert that a condition implies a consequence on the next edge
`define GTOC_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("gtoc check failed");
`endif

// ===== rtl/gtoc_pkg.sv =====
// Shared types and constants of the gyro temperature offset compensator.
// No dependencies.
package gtoc_pkg;
    localparam int NUM_BINS = 8;
    localparam int BIN_W    = $clog2(NUM_BINS);
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_COMP   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DEF_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEF_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEF_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEF_TEMP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THR      = 3'd6;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [2:0]         bin_index;
        logic               load_valid;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic signed [15:0] offset_temp;
        logic               store_enable;
        logic signed [31:0] gyro_x;
        logic signed [31:0] gyro_y;
        logic signed [31:0] gyro_z;
        logic signed [15:0] current_temp;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] corrected_x;
        logic signed [31:0] corrected_y;
        logic signed [31:0] corrected_z;
        logic [7:0]         commit_mask;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic capture;    // latch input item
        logic do_load;    // cmd 0 write
        logic upd_step;   // one bin of cmd 1
        logic fit_check;  // decide on refit
        logic scan_step;  // one bin of closest search
        logic fit_setup;  // prepare axis division
        logic div_start;
        logic fit_store;  // store slope/intercept of axis after divide
        logic mul_step;   // one multiply stage of intercept fix or final offsets
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic need_fit;
        logic div_done;
    } t_sts;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) return 32'sh7fffffff;
        if (v < -50'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

// ===== rtl/gtoc_stream_if.sv =====
// Valid/ready channel carrying one payload type.
// No dependencies; the payload type is a parameter.
interface gtoc_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/gtoc_divider.sv =====
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on gtoc_pkg.
module gtoc_divider import gtoc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [48:0] i_num,
    input  logic signed [17:0] i_den,
    output logic               o_done,
    output logic signed [48:0] o_quot
);
    logic [48:0] r_rem_q, n_rem_q;
    logic [17:0] r_rem, n_rem;
    logic [17:0] r_den;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [18:0] trial;

    always_comb begin
        trial = {r_rem, r_rem_q[48]} - {1'b0, r_den};
        n_rem_q = {r_rem_q[47:0], ~trial[18]};
        n_rem = trial[18] ? {r_rem[16:0], r_rem_q[48]} : trial[17:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= 6'd49;
                r_rem   <= '0;
                r_rem_q <= i_num[48] ? 49'(-i_num) : i_num;
                r_den   <= i_den[17] ? 18'(-i_den) : i_den;
                r_neg   <= i_num[48] ^ i_den[17];
            end else if (r_busy) begin
                r_rem   <= n_rem;
                r_rem_q <= n_rem_q;
                r_cnt   <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_neg ? 49'(-r_rem_q) : r_rem_q;
endmodule

// ===== rtl/gtoc_datapath.sv =====
// Bin storage, closest-bin scan, fit and compensation arithmetic.
// Depends on gtoc_pkg and gtoc_divider.
module gtoc_datapath import gtoc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl               i_ctl,
    input  t_in_item           i_item,
    input  logic [BIN_W-1:0]   i_bin,
    input  logic [1:0]         i_axis,
    input  logic [1:0]         i_mstage,
    input  logic signed [31:0] i_def_x,
    input  logic signed [31:0] i_def_y,
    input  logic signed [31:0] i_def_z,
    input  logic signed [15:0] i_def_temp,
    input  logic signed [15:0] i_base,
    input  logic [13:0]        i_width,
    input  logic [13:0]        i_thr,
    output t_sts               o_sts,
    output t_out_item          o_result
);
    t_in_item r_it;
    logic signed [31:0] r_off [3][NUM_BINS];
    logic signed [15:0] r_act [NUM_BINS];
    logic signed [15:0] r_sto [NUM_BINS];
    logic signed [31:0] r_slope [3];
    logic signed [31:0] r_icpt [3];
    logic signed [15:0] r_last;
    logic [7:0]         r_mask;
    // scan state
    logic signed [19:0] r_cd, r_sd;
    logic [BIN_W-1:0]   r_c, r_s;
    logic               r_cv, r_sv;
    // fit
    logic signed [48:0] r_num;
    logic signed [17:0] r_den;
    logic               r_trivial;
    logic signed [47:0] r_prod;
    logic signed [31:0] r_o [3];
    logic               r_far;
    logic               div_done;
    logic signed [48:0] quot;

    logic signed [31:0] it_off [3];
    logic signed [31:0] def_off [3];
    logic signed [19:0] tgt, nd, od, sd_ref;
    logic signed [19:0] dtmp;
    logic [BIN_W-1:0]   ref_bin;
    logic [BIN_W-1:0]   sel_bin;
    logic signed [31:0] sl;
    logic signed [17:0] mop;
    logic signed [31:0] oc;

    assign it_off[0] = r_it.offset_x;
    assign it_off[1] = r_it.offset_y;
    assign it_off[2] = r_it.offset_z;
    assign def_off[0] = i_def_x;
    assign def_off[1] = i_def_y;
    assign def_off[2] = i_def_z;

    // cmd 0 addresses the bin named in the transaction
    assign sel_bin = i_ctl.do_load ? BIN_W'(r_it.bin_index) : i_bin;

    function automatic logic signed [19:0] abs20(input logic signed [19:0] v);
        return v[19] ? -v : v;
    endfunction

    gtoc_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_ctl.div_start),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_done (div_done),
        .o_quot (quot)
    );

    always_comb begin
        tgt = 20'(i_base) + 20'(signed'({1'b0, sel_bin}) * signed'({1'b0, i_width}));
        ref_bin = r_cv ? r_c : '0;
        nd = abs20(20'(r_it.current_temp) - 20'(r_act[i_bin]));
        od = abs20(20'(r_act[i_bin]) - 20'(r_act[ref_bin]));
        sd_ref = 20'(i_base) + 20'(signed'({1'b0, i_width}) * NUM_BINS);
        dtmp = r_far ? 20'(r_it.current_temp)
                     : 20'(r_it.current_temp) - 20'(r_it.offset_temp);
        sl = r_slope[i_axis];
        mop = 18'(dtmp);
        oc = r_far ? r_icpt[i_axis] : it_off[i_axis];
    end

    assign o_sts.div_done = div_done;
    assign o_sts.need_fit = 2 * abs20(20'(r_last) - 20'(r_it.current_temp)) > 20'(i_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int b = 0; b < NUM_BINS; b++) r_off[k][b] <= '0;
                r_slope[k] <= '0;
                r_icpt[k] <= '0;
            end
            for (int b = 0; b < NUM_BINS; b++) begin
                r_act[b] <= '0;
                r_sto[b] <= '0;
            end
            r_last <= '0;
        end else begin
            if (i_ctl.do_load && 32'(r_it.bin_index) < NUM_BINS) begin
                if (r_it.load_valid) begin
                    for (int k = 0; k < 3; k++) r_off[k][sel_bin] <= it_off[k];
                    r_act[sel_bin] <= r_it.offset_temp;
                    r_sto[sel_bin] <= r_it.offset_temp;
                end else begin
                    for (int k = 0; k < 3; k++) r_off[k][sel_bin] <= def_off[k];
                    r_act[sel_bin] <= (2 * abs20(20'(i_def_temp) - tgt) <= 20'(i_width))
                                      ? i_def_temp : 16'sd0;
                    r_sto[sel_bin] <= '0;
                end
            end
            if (i_ctl.upd_step) begin
                if (2 * abs20(20'(r_it.offset_temp) - tgt) <= 20'(i_width) &&
                    abs20(20'(r_it.offset_temp) - tgt) < abs20(20'(r_act[i_bin]) - tgt)) begin
                    for (int k = 0; k < 3; k++) r_off[k][i_bin] <= it_off[k];
                    r_act[i_bin] <= r_it.offset_temp;
                    if (r_it.store_enable && 10 * abs20(20'(r_it.offset_temp)
                            - 20'(r_sto[i_bin])) > 20'(i_thr)) begin
                        r_sto[i_bin] <= r_it.offset_temp;
                    end
                end
            end
            if (i_ctl.fit_check && o_sts.need_fit) r_last <= r_it.current_temp;
            if (i_ctl.fit_store) begin
                if (r_trivial) begin
                    r_slope[i_axis] <= '0;
                    r_icpt[i_axis] <= r_off[i_axis][r_c];
                end else begin
                    r_slope[i_axis] <= sat32(50'(quot));
                end
            end
            if (i_ctl.mul_step && i_mstage == 2'd3) begin
                // intercept correction: slope * actual temp of closest bin
                r_icpt[i_axis] <= sat32(50'(r_off[i_axis][r_c]) - 50'(r_prod >>> 8));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_it   <= i_item;
            r_mask <= '0;
            r_cd   <= sd_ref;
            r_sd   <= sd_ref;
            r_c    <= '0;
            r_s    <= '0;
            r_cv   <= 1'b0;
            r_sv   <= 1'b0;
        end
        if (i_ctl.upd_step && r_it.store_enable &&
            2 * abs20(20'(r_it.offset_temp) - tgt) <= 20'(i_width) &&
            abs20(20'(r_it.offset_temp) - tgt) < abs20(20'(r_act[i_bin]) - tgt) &&
            10 * abs20(20'(r_it.offset_temp) - 20'(r_sto[i_bin])) > 20'(i_thr) &&
            32'(i_bin) < 32'd8) begin
            r_mask[3'(i_bin)] <= 1'b1;
        end
        if (i_ctl.scan_step) begin
            if (nd < r_cd) begin
                r_s <= r_c; r_sv <= r_cv; r_sd <= r_cd;
                r_c <= i_bin; r_cv <= 1'b1; r_cd <= nd;
            end else if (od > 20'(i_thr) && nd < r_sd) begin
                r_s <= i_bin; r_sv <= 1'b1; r_sd <= nd;
            end
        end
        if (i_ctl.fit_setup) begin
            r_den <= 18'(r_act[r_c]) - (r_sv ? 18'(r_act[r_s]) : 18'sd0);
            r_trivial <= !r_sv || (r_act[r_c] == (r_sv ? r_act[r_s] : 16'sd0));
            r_num <= 49'((34'(r_off[i_axis][r_c]) - 34'(r_off[i_axis][r_s])) * 256);
        end
        if (i_ctl.mul_step) begin
            // stage 0: product for intercept fix; stage 1: product for offset
            if (i_mstage == 2'd0) r_prod <= 48'(r_slope[i_axis] * 18'(r_act[r_c]));
            if (i_mstage == 2'd1) r_prod <= 48'(sl * mop);
            if (i_mstage == 2'd2) r_o[i_axis] <= sat32(50'(r_prod >>> 8) + 50'(oc));
        end
        if (i_ctl.capture) r_far <= 1'b0;
        else if (i_ctl.fit_check)
            r_far <= 2 * abs20(20'(r_it.current_temp) - 20'(r_it.offset_temp))
                     > 20'(i_width);
    end

    always_comb begin
        o_result = '0;
        if (r_it.cmd == CMD_COMP) begin
            o_result.corrected_x = r_it.gyro_x - r_o[0];
            o_result.corrected_y = r_it.gyro_y - r_o[1];
            o_result.corrected_z = r_it.gyro_z - r_o[2];
        end
        if (r_it.cmd == CMD_UPDATE) o_result.commit_mask = r_mask;
    end
endmodule

// ===== rtl/gtoc_controller.sv =====
// Sequencer of the compensator: walks bins, drives divisions and multiplies.
// Depends on gtoc_pkg.
module gtoc_controller import gtoc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_cmd,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  t_sts             i_sts,
    output t_ctl             o_ctl,
    output logic [BIN_W-1:0] o_bin,
    output logic [1:0]       o_axis,
    output logic [1:0]       o_mstage
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_LOAD, S_UPD, S_CHECK, S_SCAN, S_SETUP, S_DIV,
        S_STORE, S_ICPT, S_OFFS, S_DONE
    } t_state;

    t_state           r_state;
    logic [1:0]       r_cmd;
    logic [BIN_W-1:0] r_bin;
    logic [1:0]       r_axis;
    logic [1:0]       r_mst;
    logic             r_busy_div;

    assign o_in_ready = (r_state == S_IDLE) && !o_out_valid;
    assign o_bin = r_bin;
    assign o_axis = r_axis;
    assign o_mstage = r_mst;

    always_comb begin
        o_ctl = '0;
        o_ctl.capture   = i_in_valid && o_in_ready;
        o_ctl.do_load   = (r_state == S_LOAD);
        o_ctl.upd_step  = (r_state == S_UPD);
        o_ctl.fit_check = (r_state == S_CHECK);
        o_ctl.scan_step = (r_state == S_SCAN);
        o_ctl.fit_setup = (r_state == S_SETUP);
        o_ctl.div_start = (r_state == S_DIV) && !r_busy_div;
        o_ctl.fit_store = (r_state == S_STORE);
        o_ctl.mul_step  = (r_state == S_ICPT) || (r_state == S_OFFS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_out_valid <= 1'b0;
            r_bin <= '0; r_axis <= '0; r_mst <= '0; r_cmd <= '0;
            r_busy_div <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (o_ctl.capture) begin
                    r_cmd <= i_cmd; r_state <= S_DISPATCH; r_bin <= '0;
                end
                S_DISPATCH: begin
                    case (r_cmd)
                        CMD_LOAD:   r_state <= S_LOAD;
                        CMD_UPDATE: r_state <= S_UPD;
                        CMD_COMP:   r_state <= S_CHECK;
                        default:    r_state <= S_DONE;
                    endcase
                end
                S_LOAD: r_state <= S_DONE;
                S_UPD: begin
                    r_bin <= r_bin + 1'b1;
                    if (r_bin == BIN_W'(NUM_BINS - 1)) r_state <= S_DONE;
                end
                S_CHECK: begin
                    r_bin <= '0; r_axis <= '0;
                    r_mst <= i_sts.need_fit ? 2'd0 : 2'd1;
                    r_state <= i_sts.need_fit ? S_SCAN : S_OFFS;
                end
                S_SCAN: begin
                    r_bin <= r_bin + 1'b1;
                    if (r_bin == BIN_W'(NUM_BINS - 1)) r_state <= S_SETUP;
                end
                S_SETUP: r_state <= S_DIV;
                S_DIV: begin
                    r_busy_div <= !i_sts.div_done;
                    if (i_sts.div_done) r_state <= S_STORE;
                end
                S_STORE: begin r_mst <= '0; r_state <= S_ICPT; end
                S_ICPT: begin
                    // stage 0 multiply, stage 3 writes intercept
                    if (r_mst == 2'd0) r_mst <= 2'd3;
                    else if (r_axis == 2'd2) begin
                        r_axis <= '0; r_mst <= 2'd1; r_state <= S_OFFS;
                    end else begin
                        r_mst <= '0; r_axis <= r_axis + 2'd1; r_state <= S_SETUP;
                    end
                end
                S_OFFS: begin
                    if (r_mst == 2'd1) r_mst <= 2'd2;
                    else begin
                        r_mst <= 2'd1;
                        if (r_axis == 2'd2) r_state <= S_DONE;
                        else r_axis <= r_axis + 2'd1;
                    end
                end
                S_DONE: begin
                    o_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/gyro_temperature_offset_compensator_top.sv =====
// Channel      | Dir | Payload
// in_ch        | in  | t_in_item: cmd, bin, offsets, gyro, temperatures
// out_ch       | out | t_out_item: corrected_x/y/z, commit_mask
// cfg          | in  | i_cfg_we, i_cfg_idx, i_cfg_data (32 bits)
// One item at a time. cmd 1 walks the bins, one bin a cycle; a refit in cmd 2
// runs three serial divisions.
// Reset is synchronous and clears bins and fit. The next transaction is accepted
// from the cycle after the result has been taken.
// Depends on gtoc_pkg, gtoc_stream_if, gtoc_controller, gtoc_datapath.
module gyro_temperature_offset_compensator_top import gtoc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    gtoc_stream_if.sink            in_ch,
    gtoc_stream_if.source          out_ch,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [31:0]            i_cfg_data
);
    logic signed [31:0] r_def_x, r_def_y, r_def_z;
    logic signed [15:0] r_def_temp, r_base;
    logic [13:0]        r_width, r_thr;
    t_ctl               ctl;
    t_sts               sts;
    logic [BIN_W-1:0]   bin;
    logic [1:0]         axis, mst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_x <= '0; r_def_y <= '0; r_def_z <= '0; r_def_temp <= '0;
            r_base <= 16'sd1000; r_width <= 14'd500; r_thr <= 14'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEF_X:    r_def_x <= i_cfg_data;
                REG_DEF_Y:    r_def_y <= i_cfg_data;
                REG_DEF_Z:    r_def_z <= i_cfg_data;
                REG_DEF_TEMP: r_def_temp <= i_cfg_data[15:0];
                REG_BASE:     r_base <= i_cfg_data[15:0];
                REG_WIDTH:    r_width <= i_cfg_data[13:0];
                REG_THR:      r_thr <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    gtoc_controller u_ctl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_cmd(in_ch.data.cmd), .o_in_ready(in_ch.ready),
        .i_out_ready(out_ch.ready), .o_out_valid(out_ch.valid),
        .i_sts(sts), .o_ctl(ctl), .o_bin(bin), .o_axis(axis), .o_mstage(mst)
    );

    gtoc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_item(in_ch.data),
        .i_bin(bin), .i_axis(axis), .i_mstage(mst),
        .i_def_x(r_def_x), .i_def_y(r_def_y), .i_def_z(r_def_z),
        .i_def_temp(r_def_temp), .i_base(r_base), .i_width(r_width), .i_thr(r_thr),
        .o_sts(sts), .o_result(out_ch.data)
    );
endmodule

// ===== rtl/gtoc_checker.sv =====
// Port-level checker for the compensator, bound to the top level.
// Depends on gtoc_pkg and the assertion macro header.
`include "gyro_temperature_offset_compensator_top_defines.svh"
module gtoc_checker import gtoc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input t_out_item out_data
);
    `GTOC_ASSERT_IMP(a_no_accept_while_out, i_clk, i_rst_n, out_valid, !in_ready)
    `GTOC_ASSERT_NXT(a_accept_drops_ready, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
    `GTOC_ASSERT_NXT(a_out_holds, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    `GTOC_ASSERT_NXT(a_data_holds, i_clk, i_rst_n, out_valid && !out_ready, $stable(out_data))
endmodule

bind gyro_temperature_offset_compensator_top gtoc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
